### rtl/q2e_pkg.sv
//------------------------------------------------------------------------------
// q2e_pkg: shared constants and helpers for the quaternion to Euler converter
// Holds the CORDIC angle table and working-precision constants.
//------------------------------------------------------------------------------
package q2e_pkg;

	localparam int QUAT_WIDTH_DEF      = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 7;

	localparam int CORDIC_FRAC  = 16;
	localparam int CORDIC_STEPS = 20;
	// CORDIC datapath width: sums of products plus headroom for gain
	localparam int CW = 38;
	// Angle accumulator width (+/-180 deg Q16 plus margin)
	localparam int ZW = 26;

	localparam logic signed [ZW-1:0] DEG90 = ZW'(90 <<< CORDIC_FRAC);
	localparam logic signed [ZW-1:0] DEG180 = ZW'(180 <<< CORDIC_FRAC);

	// atan(2^-i) in degrees, Q16
	function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:  r = ZW'(2949120);
			5'd1:  r = ZW'(1740967);
			5'd2:  r = ZW'(919879);
			5'd3:  r = ZW'(466945);
			5'd4:  r = ZW'(234379);
			5'd5:  r = ZW'(117304);
			5'd6:  r = ZW'(58666);
			5'd7:  r = ZW'(29335);
			5'd8:  r = ZW'(14668);
			5'd9:  r = ZW'(7334);
			5'd10: r = ZW'(3667);
			5'd11: r = ZW'(1833);
			5'd12: r = ZW'(917);
			5'd13: r = ZW'(458);
			5'd14: r = ZW'(229);
			5'd15: r = ZW'(115);
			5'd16: r = ZW'(57);
			5'd17: r = ZW'(29);
			5'd18: r = ZW'(14);
			5'd19: r = ZW'(7);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### rtl/q2e_cordic_stage.sv
//------------------------------------------------------------------------------
// q2e_cordic_stage: one registered vectoring CORDIC micro-rotation
// Rotates (x,y) toward the x axis by atan(2^-STEP) and accumulates the angle.
//------------------------------------------------------------------------------
module q2e_cordic_stage
	import q2e_pkg::*;
#(
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	output logic signed [CW-1:0] x_s1,
	output logic signed [CW-1:0] y_s1,
	output logic signed [ZW-1:0] z_s1
);

	logic signed [CW-1:0] dx, dy;
	localparam logic signed [ZW-1:0] A = atan_tab(5'(STEP));

	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[CW-1]) begin
				x_s1 <= x_in + dx;
				y_s1 <= y_in - dy;
				z_s1 <= z_in + A;
			end else begin
				x_s1 <= x_in - dx;
				y_s1 <= y_in + dy;
				z_s1 <= z_in - A;
			end
		end
	end

endmodule

### rtl/q2e_atan2.sv
//------------------------------------------------------------------------------
// q2e_atan2: pipelined vectoring CORDIC atan2
// Quadrant prerotation stage, then one register stage per micro-rotation.
// Output angle in degrees Q16, after the prerotation and all micro-rotation stages.
//------------------------------------------------------------------------------
module q2e_atan2
	import q2e_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [CW-1:0] x_in,
	input  logic                 force_in,
	input  logic signed [ZW-1:0] force_val,
	output logic signed [ZW-1:0] z_out
);

	logic signed [CW-1:0] xp [CORDIC_STEPS+1];
	logic signed [CW-1:0] yp [CORDIC_STEPS+1];
	logic signed [ZW-1:0] zp [CORDIC_STEPS+1];
	logic                 zero_s [CORDIC_STEPS+1];
	logic signed [ZW-1:0] fv_s [CORDIC_STEPS+1];

	// prerotation for left half plane
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= force_in || (x_in == '0 && y_in == '0);
			fv_s[0]   <= force_in ? force_val : '0;
			if (x_in[CW-1]) begin
				if (!y_in[CW-1]) begin
					xp[0] <= y_in;
					yp[0] <= -x_in;
					zp[0] <= DEG90;
				end else begin
					xp[0] <= -y_in;
					yp[0] <= x_in;
					zp[0] <= -DEG90;
				end
			end else begin
				xp[0] <= x_in;
				yp[0] <= y_in;
				zp[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		q2e_cordic_stage #(.STEP(i)) u_stage (
			.clk  (clk),
			.en   (en),
			.x_in (xp[i]),
			.y_in (yp[i]),
			.z_in (zp[i]),
			.x_s1 (xp[i+1]),
			.y_s1 (yp[i+1]),
			.z_s1 (zp[i+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				fv_s[i+1]   <= fv_s[i];
			end
		end
	end

	assign z_out = zero_s[CORDIC_STEPS] ? fv_s[CORDIC_STEPS] : zp[CORDIC_STEPS];

endmodule

### rtl/q2e_isqrt.sv
//------------------------------------------------------------------------------
// q2e_isqrt: pipelined floor integer square root
// One result bit per register stage (restoring, digit by digit).
//------------------------------------------------------------------------------
module q2e_isqrt
	import q2e_pkg::*;
#(
	parameter int NW = 62
) (
	input  logic                clk,
	input  logic                en,
	input  logic [NW-1:0]       n_in,
	output logic [NW/2-1:0]     root
);

	localparam int RW = NW / 2;

	logic [NW-1:0] rem_p  [RW+1];
	logic [RW-1:0] res_p  [RW+1];

	assign rem_p[0] = n_in;
	assign res_p[0] = '0;

	for (genvar k = 0; k < RW; k++) begin : g_bit
		localparam int B = RW - 1 - k;
		logic [NW-1:0] trial;
		logic [NW-1:0] cand;
		// trial = (res << (B+1)) + (1 << 2B)
		assign cand  = NW'(res_p[k]) << (B + 1);
		assign trial = cand | (NW'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_p[k] >= trial) begin
					rem_p[k+1] <= rem_p[k] - trial;
					res_p[k+1] <= res_p[k] | (RW'(1) << B);
				end else begin
					rem_p[k+1] <= rem_p[k];
					res_p[k+1] <= res_p[k];
				end
			end
		end
	end

	assign root = res_p[RW];

endmodule

### rtl/q2e_front.sv
//------------------------------------------------------------------------------
// q2e_front: product and sum stages
// Stage 1 forms the nine products, stage 2 the sine/cosine terms, stage 3 the
// asin clamp test and 1-s^2 square (its own multiplier stage).
//------------------------------------------------------------------------------
module q2e_front
	import q2e_pkg::*;
#(
	parameter int QW = QUAT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [QW-1:0] qw,
	input  logic signed [QW-1:0] qx,
	input  logic signed [QW-1:0] qy,
	input  logic signed [QW-1:0] qz,
	output logic signed [CW-1:0] sin_r_s3,
	output logic signed [CW-1:0] cos_r_s3,
	output logic signed [CW-1:0] sin_y_s3,
	output logic signed [CW-1:0] cos_y_s3,
	output logic signed [CW-1:0] s_s3,
	output logic [61:0]          rem_s3,
	output logic                 clamp_s3,
	output logic                 neg_s3
);

	localparam int PF    = 2 * (QW - 2);
	localparam int SH    = (PF > 30) ? PF - 30 : 0;
	localparam int WF    = PF - SH;
	localparam int PW    = 2 * QW;
	localparam logic signed [CW-1:0] ONE = CW'(64'sd1 <<< WF);

	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= qw * qx;
			yz_s1 <= qy * qz;
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			wy_s1 <= qw * qy;
			zx_s1 <= qz * qx;
			wz_s1 <= qw * qz;
			xy_s1 <= qx * qy;
			zz_s1 <= qz * qz;
		end
	end

	function automatic logic signed [CW-1:0] sc(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = p >>> SH;
		return CW'(t);
	endfunction

	logic signed [CW-1:0] sin_r_s2, cos_r_s2, sin_y_s2, cos_y_s2, s_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sin_r_s2 <= (sc(wx_s1) + sc(yz_s1)) <<< 1;
			cos_r_s2 <= ONE - ((sc(xx_s1) + sc(yy_s1)) <<< 1);
			sin_y_s2 <= (sc(wz_s1) + sc(xy_s1)) <<< 1;
			cos_y_s2 <= ONE - ((sc(yy_s1) + sc(zz_s1)) <<< 1);
			s_s2     <= (sc(wy_s1) - sc(zx_s1)) <<< 1;
		end
	end

	// |s| < one here when not clamped, so s fits in WF+1 bits
	logic [30:0] s_mag;
	logic [61:0] s_sq;
	assign s_mag = s_s2[CW-1] ? 31'(-s_s2) : 31'(s_s2);
	assign s_sq  = s_mag * s_mag;

	always_ff @(posedge clk) begin
		if (en) begin
			sin_r_s3 <= sin_r_s2;
			cos_r_s3 <= cos_r_s2;
			sin_y_s3 <= sin_y_s2;
			cos_y_s3 <= cos_y_s2;
			s_s3     <= s_s2;
			clamp_s3 <= (s_s2 >= ONE) || (s_s2 <= -ONE);
			neg_s3   <= s_s2[CW-1];
			rem_s3   <= (62'(1) << (2 * WF)) - s_sq;
		end
	end

endmodule

### rtl/quaternion_to_euler_angles.sv
// Path: front product stages, isqrt stages, atan2 stages and the output register.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds on a stall, with an output register so input is still taken while the
// last result waits, as long as no word sits at the pipeline tail.
// Reset: arst_n clears the valid bits only; data registers are not reset.
//------------------------------------------------------------------------------
// quaternion_to_euler_angles: pipelined quaternion to Euler angle converter
// Product stages, isqrt pipeline for the asin cosine leg, three CORDIC atan2.
//------------------------------------------------------------------------------
module quaternion_to_euler_angles
	import q2e_pkg::*;
#(
	parameter int QUAT_WIDTH      = QUAT_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// w, x, y, z from bit 0 up
	input  logic [4*QUAT_WIDTH-1:0] s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// angle_x[15:0], angle_y[31:16], angle_z[46:32], pad[47]
	output logic [47:0]           m_tdata,
	// clamped
	output logic                  m_tuser
);

	localparam int QW   = QUAT_WIDTH;
	localparam int RW   = 31;
	localparam int LAT  = 3 + RW + CORDIC_STEPS + 1;
	localparam int SH   = CORDIC_FRAC - ANGLE_FRAC_BITS;

	logic en;
	logic [LAT-1:0] vld_q;
	logic out_full_q;

	// pipeline moves whenever the output register can take the tail word
	assign en       = !out_full_q || m_tready || !vld_q[LAT-1];
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	logic signed [CW-1:0] sin_r, cos_r, sin_y, cos_y, s3;
	logic [61:0] rem3;
	logic clamp3, neg3;

	q2e_front #(.QW(QW)) u_front (
		.clk(clk), .en(en),
		.qw(s_tdata[QW-1:0]), .qx(s_tdata[2*QW-1:QW]),
		.qy(s_tdata[3*QW-1:2*QW]), .qz(s_tdata[4*QW-1:3*QW]),
		.sin_r_s3(sin_r), .cos_r_s3(cos_r), .sin_y_s3(sin_y), .cos_y_s3(cos_y),
		.s_s3(s3), .rem_s3(rem3), .clamp_s3(clamp3), .neg_s3(neg3)
	);

	logic [RW-1:0] root;
	q2e_isqrt #(.NW(62)) u_sqrt (.clk(clk), .en(en), .n_in(rem3), .root(root));

	// delay lines matching the isqrt depth
	logic signed [CW-1:0] dsr [RW+1], dcr [RW+1], dsy [RW+1], dcy [RW+1], ds [RW+1];
	logic dcl [RW+1], dng [RW+1];
	assign dsr[0] = sin_r; assign dcr[0] = cos_r; assign dsy[0] = sin_y;
	assign dcy[0] = cos_y; assign ds[0] = s3; assign dcl[0] = clamp3; assign dng[0] = neg3;
	for (genvar k = 0; k < RW; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				dsr[k+1] <= dsr[k]; dcr[k+1] <= dcr[k]; dsy[k+1] <= dsy[k];
				dcy[k+1] <= dcy[k]; ds[k+1] <= ds[k]; dcl[k+1] <= dcl[k];
				dng[k+1] <= dng[k];
			end
		end
	end

	logic signed [ZW-1:0] zx, zy, zz;
	logic signed [ZW-1:0] clamp_val;
	assign clamp_val = dng[RW] ? -DEG90 : DEG90;

	q2e_atan2 u_ax (.clk(clk), .en(en), .y_in(dsr[RW]), .x_in(dcr[RW]),
		.force_in(1'b0), .force_val('0), .z_out(zx));
	q2e_atan2 u_ay (.clk(clk), .en(en), .y_in(dsy[RW]), .x_in(dcy[RW]),
		.force_in(1'b0), .force_val('0), .z_out(zy));
	q2e_atan2 u_az (.clk(clk), .en(en), .y_in(ds[RW]), .x_in(CW'(root)),
		.force_in(dcl[RW]), .force_val(clamp_val), .z_out(zz));

	logic cl_d [CORDIC_STEPS+2];
	assign cl_d[0] = dcl[RW];
	for (genvar k = 0; k <= CORDIC_STEPS; k++) begin : g_cl
		always_ff @(posedge clk) begin
			if (en) cl_d[k+1] <= cl_d[k];
		end
	end

	function automatic logic [15:0] rnd(input logic signed [ZW-1:0] z);
		logic signed [ZW-1:0] c, r;
		c = (z > DEG180) ? DEG180 : ((z < -DEG180) ? -DEG180 : z);
		r = (c + ZW'((64'sd1 <<< SH) >>> 1)) >>> SH;
		return r[15:0];
	endfunction

	logic [47:0] out_q;
	logic        user_q;
	logic [15:0] ax, ay, az;
	assign ax = rnd(zx);
	assign ay = rnd(zy);
	assign az = rnd(zz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (en) begin
			out_full_q <= vld_q[LAT-1] || (out_full_q && !m_tready);
		end else if (m_tready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_q[LAT-1]) begin
			out_q  <= {1'b0, az[14:0], ay, ax};
			user_q <= cl_d[CORDIC_STEPS+1];
		end
	end

	assign m_tvalid = out_full_q;
	assign m_tdata  = out_q;
	assign m_tuser  = user_q;

endmodule

### rtl/quaternion_to_euler_angles_chk.sv
//------------------------------------------------------------------------------
// quaternion_to_euler_angles_chk: port-level checker
// Watches the output stream for stability, clamp values and the pad bit.
//------------------------------------------------------------------------------
module quaternion_to_euler_angles_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[46:32] == 15'd11520 || m_tdata[46:32] == 15'h5300))
		else $error("clamped word without +/-90");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[47])
		else $error("pad bit set");

endmodule

bind quaternion_to_euler_angles quaternion_to_euler_angles_chk u_chk (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);

### tb/sv/q2e_checker.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// q2e_checker: scoreboard for the quaternion to Euler angle converter
// Watches both stream channels, predicts the three angles and the clamp flag
// for every accepted quaternion word and compares each output word in order.
//------------------------------------------------------------------------------
module q2e_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        m_tuser,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic        clamped;
		logic [14:0] angle_z;
		logic [15:0] angle_y;
		logic [15:0] angle_x;
	} euler_t;

	euler_t angles_due[$];

	localparam longint ONE_Q28 = 64'sd1 <<< 28;

	function automatic longint shr_floor(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint sqrt_floor(input longint n);
		longint res, bitv;
		res = 0;
		bitv = 64'sd1 <<< 62;
		while (bitv > n)
			bitv = bitv >>> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >>> 1) + bitv;
			end else begin
				res = res >>> 1;
			end
			bitv = bitv >>> 2;
		end
		return res;
	endfunction

	// vectoring CORDIC, result in degrees Q16
	function automatic longint atan2_deg(input longint yi, input longint xi);
		longint xa, ya, za, t, dx, dy;
		xa = xi;
		ya = yi;
		za = 0;
		if (xa == 0 && ya == 0)
			return 0;
		if (xa < 0) begin
			t = xa;
			if (ya >= 0) begin
				xa = ya; ya = -t; za = 64'sd90 <<< 16;
			end else begin
				xa = -ya; ya = t; za = -(64'sd90 <<< 16);
			end
		end
		for (int i = 0; i < 20; i++) begin
			dx = shr_floor(ya, i);
			dy = shr_floor(xa, i);
			if (ya >= 0) begin
				xa = xa + dx; ya = ya - dy; za = za + q2e_pkg::atan_tab(5'(i));
			end else begin
				xa = xa - dx; ya = ya + dy; za = za - q2e_pkg::atan_tab(5'(i));
			end
		end
		return za;
	endfunction

	function automatic logic [15:0] to_deg128(input longint za);
		longint lim;
		lim = 64'sd180 <<< 16;
		if (za > lim) za = lim;
		if (za < -lim) za = -lim;
		return 16'(shr_floor(za + 256, 9));
	endfunction

	function automatic euler_t quat_to_euler(input logic [63:0] q);
		longint w, x, y, z, sr, cr, sy, cy, s, az;
		euler_t e;
		w = longint'($signed(q[15:0]));
		x = longint'($signed(q[31:16]));
		y = longint'($signed(q[47:32]));
		z = longint'($signed(q[63:48]));
		sr = 2 * (w * x + y * z);
		cr = ONE_Q28 - 2 * (x * x + y * y);
		s = 2 * (w * y - z * x);
		sy = 2 * (w * z + x * y);
		cy = ONE_Q28 - 2 * (y * y + z * z);
		e.clamped = 1'b0;
		if (s >= ONE_Q28) begin
			az = 64'sd90 <<< 16; e.clamped = 1'b1;
		end else if (s <= -ONE_Q28) begin
			az = -(64'sd90 <<< 16); e.clamped = 1'b1;
		end else begin
			az = atan2_deg(s, sqrt_floor(ONE_Q28 * ONE_Q28 - s * s));
		end
		e.angle_x = to_deg128(atan2_deg(sr, cr));
		e.angle_y = to_deg128(atan2_deg(sy, cy));
		e.angle_z = 15'(to_deg128(az));
		return e;
	endfunction

	assign pending = angles_due.size();

	always @(posedge clk or negedge arst_n) begin
		euler_t want, got;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (s_tvalid && s_tready)
				angles_due.push_back(quat_to_euler(s_tdata));
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[46:0]};
				if (angles_due.size() == 0) begin
					$display("%0t: unexpected word %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = angles_due.pop_front();
					if (want.angle_x !== got.angle_x || want.angle_y !== got.angle_y
							|| want.angle_z !== got.angle_z || want.clamped !== got.clamped) begin
						$display("%0t: mismatch expected x=%h y=%h z=%h c=%b actual x=%h y=%h z=%h c=%b",
							$time, want.angle_x, want.angle_y, want.angle_z, want.clamped,
							got.angle_x, got.angle_y, got.angle_z, got.clamped);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_top: stimulus and verdict for the quaternion to Euler angle converter
// Directed corner quaternions, then random unit-ish and raw words under
// several source/sink idling phases; a checker module scores the output.
//------------------------------------------------------------------------------
module tb_top;

	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;
	int          fail_count;
	int          pending;
	int          idle_cycles;
	int          src_idle_pct;
	int          sink_stall_pct;

	quaternion_to_euler_angles u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	q2e_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// sink side stalls at random
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= sink_stall_pct);

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [15:0] rand_comp(input int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($signed(11'($urandom)));
			default: return 16'($urandom_range(32767)) - 16'd16384;
		endcase
	endfunction

	// one word, held until accepted; optional idle before it
	task automatic send_word(input logic [63:0] q);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= q;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_quat(input logic [15:0] w, x, y, z);
		send_word({z, y, x, w});
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [15:0] q [4];
		int mode;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		idle_cycles = 0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, zeros, extremes, gimbal lock, half turns
		send_quat(16'h4000, '0, '0, '0);
		send_quat('0, '0, '0, '0);
		send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send_quat(16'h2d41, '0, 16'h2d41, '0);
		send_quat(16'h2d41, '0, 16'hd2bf, '0);
		send_quat(16'h2d42, '0, 16'h2d42, '0);
		send_quat(16'h2000, 16'h2000, 16'h2000, 16'h2000);
		send_quat(16'h2000, 16'he000, 16'h2000, 16'he000);
		send_quat('0, 16'h4000, '0, '0);
		send_quat('0, '0, 16'h4000, '0);
		send_quat('0, '0, '0, 16'h4000);
		send_quat(16'h2d41, 16'h2d41, '0, '0);
		send_quat(16'h2d41, '0, '0, 16'hd2bf);
		send_quat(16'h0001, 16'hffff, 16'h0001, 16'hffff);
		send_quat(16'h5555, 16'haaaa, 16'h1234, 16'hedcb);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct   = (ph == 1 || ph == 3) ? (ph == 3 ? 32 : 76) : 0;
			sink_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 32 : 76) : 0;
			for (int n = 0; n < 125; n++) begin
				mode = $urandom_range(2);
				foreach (q[k])
					q[k] = rand_comp(mode);
				// sometimes force the sine term near or past one
				if ($urandom_range(9) == 0) begin
					q[0] = 16'h2d41 + 16'($urandom_range(4)) - 16'd2;
					q[2] = ($urandom_range(1) != 0) ? q[0] : -q[0];
					q[1] = '0;
					q[3] = 16'($urandom_range(2)) - 16'd1;
				end
				send_quat(q[0], q[1], q[2], q[3]);
			end
			drain();
		end

		repeat (80) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### quaternion_to_euler_angles.f
rtl/q2e_pkg.sv
rtl/q2e_cordic_stage.sv
rtl/q2e_atan2.sv
rtl/q2e_isqrt.sv
rtl/q2e_front.sv
rtl/quaternion_to_euler_angles.sv
rtl/quaternion_to_euler_angles_chk.sv
tb/sv/q2e_checker.sv
tb/sv/tb_top.sv
